// ----- hw/rtl/vtp_pkg.sv -----
// Shared types, constants and helpers for the vertex transform block.
package vtp_pkg;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_DIR   = 2'd2
    } mode_t;

    // Width of a transformed coordinate before clamping.
    localparam int CW = 67;
    // Quotient bits produced by the divider, one per stage.
    localparam int QB = 33;
    // Number of matrix elements.
    localparam int ELEMS = 16;

    // Side information that travels beside the divider.
    typedef struct packed {
        logic             valid;
        logic             divide;
        logic             nodiv;
        logic [2:0]       neg;
        logic [2:0]       psat;
        logic [2:0][31:0] pval;
    } side_t;

    // Clamp a wide coordinate to 32 bits; bit 32 of the result flags a clamp.
    function automatic logic [32:0] sat32(input logic [CW-1:0] v);
        logic flag;
        logic [31:0] val;
        flag = !((&v[CW-1:31]) || (~|v[CW-1:31]));
        val = flag ? (v[CW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[31:0];
        return {flag, val};
    endfunction

endpackage

// ----- hw/rtl/vertex_transform_perspective.sv -----
// Top level: 4x4 fixed-point vertex transform with perspective divide.
// An input passes stage A, stage B, the divider stages and the output register in turn.
// Throughput: one item per cycle; the 33-stage divider takes one quotient bit per stage.
// The whole pipeline holds while a result waits on m_tready; load items give no result.
// Reset: synchronous, active low; the matrix returns to identity and the pipeline empties.
module vertex_transform_perspective #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[3:0], entry_value[35:4], in_x[67:36], in_y[99:68], in_z[131:100], zero pad
    input  logic [135:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata,
    // no_divide[0], saturated[1]
    output logic [1:0]   m_tuser
);
    import vtp_pkg::*;

    localparam int NW = CW + FRAC_BITS;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    // Input fields.
    mode_t       in_mode;
    logic [3:0]  in_idx;
    logic [31:0] in_val;
    logic [31:0] in_v [3];
    logic        en;
    logic        accept;

    assign in_mode = mode_t'(s_tuser);
    assign in_idx  = s_tdata[3:0];
    assign in_val  = s_tdata[35:4];
    assign in_v[0] = s_tdata[67:36];
    assign in_v[1] = s_tdata[99:68];
    assign in_v[2] = s_tdata[131:100];

    // The pipeline advances whenever the output register can take a new value.
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Matrix store, column major; element (r, c) sits at c*4+r.
    logic [31:0] mat_reg [ELEMS];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ELEMS; i++) begin
                mat_reg[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : 32'd0;
            end
        end else if (accept && in_mode == MODE_LOAD) begin
            mat_reg[in_idx] <= in_val;
        end
    end

    // Stage A: twelve products and the translation column.
    logic               a_valid_reg;
    logic               a_point_reg;
    logic signed [63:0] prod_reg [4][3];
    logic [31:0]        tr_reg   [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= accept && (in_mode == MODE_POINT || in_mode == MODE_DIR);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_point_reg <= (in_mode == MODE_POINT);
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r][k] <= $signed(mat_reg[k*4+r]) * $signed(in_v[k]);
                end
                tr_reg[r] <= mat_reg[12+r];
            end
        end
    end

    // Stage B: exact sums, floor to the fixed format, add translation in point mode.
    logic signed [65:0]   sum   [4];
    logic signed [65:0]   fl    [4];
    logic signed [CW-1:0] crd   [4];
    logic [CW-1:0]        mag   [4];
    logic [32:0]          sv    [3];
    logic                 w_zero;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum[r] = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2]);
            fl[r]  = sum[r] >>> FRAC_BITS;
            crd[r] = CW'(fl[r]) + (a_point_reg ? CW'($signed(tr_reg[r])) : CW'(0));
            mag[r] = crd[r][CW-1] ? CW'(-crd[r]) : CW'(crd[r]);
        end
        for (int r = 0; r < 3; r++) begin
            sv[r] = sat32(crd[r]);
        end
        w_zero = (crd[3] == '0);
    end

    logic [NW-1:0] b_num_reg [3];
    logic [CW-1:0] b_den_reg;
    side_t         b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_side_reg <= '0;
        end else if (en) begin
            b_side_reg.valid  <= a_valid_reg;
            b_side_reg.divide <= a_point_reg && !w_zero;
            b_side_reg.nodiv  <= a_point_reg && w_zero;
            for (int r = 0; r < 3; r++) begin
                b_side_reg.neg[r]  <= crd[r][CW-1] ^ crd[3][CW-1];
                b_side_reg.psat[r] <= sv[r][32];
                b_side_reg.pval[r] <= sv[r][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                b_num_reg[r] <= {mag[r], FRAC_BITS'(0)};
            end
            b_den_reg <= mag[3];
        end
    end

    // Divider lanes for x, y and z.
    logic [QB-1:0] quo [3];
    logic          ovf [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            vtp_div_pipe #(
                .NW (NW),
                .DW (CW)
            ) u_div (
                .aclk (aclk),
                .en   (en),
                .num  (b_num_reg[g]),
                .den  (b_den_reg),
                .quo  (quo[g]),
                .ovf  (ovf[g])
            );
        end
    endgenerate

    // Side information delay line matching the divider depth.
    side_t side_reg [QB];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QB; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= b_side_reg;
            for (int i = 1; i < QB; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Final sign, clamp and selection between divided and undivided values.
    side_t       last;
    logic [31:0] res  [3];
    logic [2:0]  rsat;
    logic [QB-1:0] negq;

    always_comb begin
        last = side_reg[QB-1];
        for (int r = 0; r < 3; r++) begin
            negq = -quo[r];
            if (!last.divide) begin
                res[r]  = last.pval[r];
                rsat[r] = last.psat[r];
            end else if (last.neg[r]) begin
                if (ovf[r] || quo[r] > QB'(33'h1_0000_0000) >> 1) begin
                    res[r]  = 32'h8000_0000;
                    rsat[r] = 1'b1;
                end else begin
                    res[r]  = negq[31:0];
                    rsat[r] = 1'b0;
                end
            end else begin
                if (ovf[r] || quo[r] > QB'(32'h7FFF_FFFF)) begin
                    res[r]  = 32'h7FFF_FFFF;
                    rsat[r] = 1'b1;
                end else begin
                    res[r]  = quo[r][31:0];
                    rsat[r] = 1'b0;
                end
            end
        end
    end

    // Output register.
    logic [95:0] m_data_reg;
    logic [1:0]  m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {res[2], res[1], res[0]};
            m_user_reg <= {|rsat, last.nodiv};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // A load transfer never enters the arithmetic pipeline.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_mode == MODE_LOAD) |=> !a_valid_reg)
        else $error("load item entered the transform pipeline");

    // A held output freezes the first stage.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(a_valid_reg))
        else $error("pipeline moved while stalled");

    // A load transfer lands in the addressed matrix element.
    a_load_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_mode == MODE_LOAD) |=> (mat_reg[$past(in_idx)] == $past(in_val)))
        else $error("matrix element not written");
`endif

endmodule

// ----- hw/rtl/vtp_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module vtp_div_pipe #(
    parameter int NW = 83,
    parameter int DW = 67
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    output logic [vtp_pkg::QB-1:0] quo,
    output logic                 ovf
);
    import vtp_pkg::*;

    localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [RW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB];
    logic          ovf_reg [QB];

    genvar s;
    generate
        for (s = 0; s < QB; s++) begin : g_step
            logic [RW-1:0] rem_in;
            logic [DW-1:0] d_in;
            logic [QB-1:0] q_in;
            logic          o_in;
            logic [RW-1:0] dsh;
            logic          ge;
            logic [RW-1:0] rem_next;
            logic [QB-1:0] q_next;

            // First stage also checks whether the quotient overflows QB bits.
            if (s == 0) begin : g_first
                assign rem_in = RW'(num);
                assign d_in   = den;
                assign q_in   = '0;
                assign o_in   = (RW'(num) >= (RW'(den) << QB));
            end else begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign d_in   = den_reg[s-1];
                assign q_in   = q_reg[s-1];
                assign o_in   = ovf_reg[s-1];
            end

            // Trial subtract of the shifted divisor.
            always_comb begin
                dsh = RW'(d_in) << (QB - 1 - s);
                ge = (rem_in >= dsh);
                rem_next = ge ? (rem_in - dsh) : rem_in;
                q_next = q_in;
                q_next[QB-1-s] = ge;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= d_in;
                    q_reg[s]   <= q_next;
                    ovf_reg[s] <= o_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];
    assign ovf = ovf_reg[QB-1];

endmodule
